// ===== design/pinned_lru_page_cache_tags_assert.svh =====
// assertion macros for the pinned lru page cache tag block
`ifndef PINNED_LRU_PAGE_CACHE_TAGS_ASSERT_SVH
`define PINNED_LRU_PAGE_CACHE_TAGS_ASSERT_SVH
`ifndef SYNTHESIS
`define PLCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plct assertion failed");
`define PLCT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plct assertion failed");
`else
`define PLCT_ASSERT_IMP(lbl, ante, cons)
`define PLCT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/plct_pkg.sv =====
// shared constants, types and helpers for the page cache tag block
package plct_pkg;

  localparam int SLOTS     = 3;
  localparam int PAGE_BITS = 16;
  localparam int STAMP_W   = 32;
  localparam int CNT_W     = 16;
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMP_W     = (PAGE_BITS > CNT_W) ? PAGE_BITS : CNT_W;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 2;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [STAMP_W-1:0]   stamp_t;

  localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PIN   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UNPIN = 2'd2;

  localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOSLOT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNPIN   = 3'd5;

  // register index as seen on the word address
  localparam logic REG_PAGE_COUNT = 1'b0;

  // search state handed from cell to cell
  typedef struct packed {
    logic   vld;
    logic   hit;
    idx_t   hit_idx;
    logic   free;
    idx_t   free_idx;
    logic   vic;
    idx_t   vic_idx;
    stamp_t vic_stamp;
  } scan_t;

  // update broadcast to the row of cells
  typedef struct packed {
    logic   en;
    idx_t   idx;
    logic   load;
    logic   pin_we;
    logic   pin_val;
    stamp_t stamp;
  } wr_t;

  function automatic logic [SLOT_W-1:0] slot_field(input idx_t idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

endpackage

// ===== design/plct_cell.sv =====
// one cache slot: tag, stamp and pin state plus its step of the search chain
module plct_cell import plct_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  idx_t  cell_idx,
  input  page_t req_page,
  input  scan_t scan_in,
  output scan_t scan_out,
  input  wr_t   wr
);

  logic   valid_r;
  logic   pinned_r;
  page_t  page_r;
  stamp_t stamp_r;
  scan_t  scan_r;
  scan_t  scan_nxt;
  logic   sel;

  assign sel = wr.en && (wr.idx == cell_idx);

  always_comb begin
    scan_nxt = scan_in;
    if (!scan_in.hit && valid_r && (page_r == req_page)) begin
      scan_nxt.hit     = 1'b1;
      scan_nxt.hit_idx = cell_idx;
    end
    if (!scan_in.free && !valid_r) begin
      scan_nxt.free     = 1'b1;
      scan_nxt.free_idx = cell_idx;
    end
    // strict compare keeps the lowest index on equal stamps
    if (valid_r && !pinned_r && (!scan_in.vic || (stamp_r < scan_in.vic_stamp))) begin
      scan_nxt.vic       = 1'b1;
      scan_nxt.vic_idx   = cell_idx;
      scan_nxt.vic_stamp = stamp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r.vld <= 1'b0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      pinned_r <= 1'b0;
    end else if (sel) begin
      if (wr.load) begin
        valid_r <= 1'b1;
      end
      if (wr.pin_we) begin
        pinned_r <= wr.pin_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      if (wr.load) begin
        page_r <= req_page;
      end
      stamp_r <= wr.stamp;
    end
  end

  assign scan_out = scan_r;

endmodule

// ===== design/pinned_lru_page_cache_tags.sv =====
// top level: request control, decision on the scan result and config registers
// the request passes launch_r and the scan register of each slot cell before out_valid is registered
// a new item is taken only once the last one's update is applied (busy); the search walks the row of
// slot cells one cell per cycle, then the decision on the scan result applies the update
// the receiver cannot stall: out_valid is high for exactly one cycle per item
// synchronous reset (rst_n low) empties all slots, clears pins, stamp clock and page_count
`include "pinned_lru_page_cache_tags_assert.svh"
module pinned_lru_page_cache_tags import plct_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   in_func,
  input  page_t               in_page,
  input  logic                in_page_empty,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_slot,
  output logic                out_slot_found,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  logic                busy_r;
  logic                launch_r;
  logic [FUNC_W-1:0]   func_r;
  page_t               page_r;
  logic                empty_r;
  logic [CNT_W-1:0]    page_count_r;
  stamp_t              use_clock_r;
  stamp_t              use_clock_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_found_r;

  logic                accept;
  scan_t               chain [SLOTS+1];
  scan_t               fin;
  wr_t                 wr;
  wr_t                 wr_dec;
  logic [STATUS_W-1:0] status_dec;
  idx_t                idx_dec;
  logic                found_dec;
  logic                legal;
  logic                is_pin;
  logic                is_unpin;
  stamp_t              stamp1;
  stamp_t              stamp2;
  logic                cfg_wr;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_comb begin
    chain[0]     = '0;
    chain[0].vld = launch_r;
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    plct_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .req_page (page_r),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1]),
      .wr       (wr)
    );
  end

  assign fin = chain[SLOTS];

  assign legal    = {{(CMP_W-PAGE_BITS){1'b0}}, page_r} <
                    {{(CMP_W-CNT_W){1'b0}}, page_count_r};
  assign is_pin   = (func_r == FUNC_PIN);
  assign is_unpin = (func_r == FUNC_UNPIN);
  assign stamp1   = use_clock_r + stamp_t'(1);
  assign stamp2   = use_clock_r + stamp_t'(2);

  always_comb begin
    wr_dec        = '0;
    use_clock_nxt = use_clock_r;
    status_dec    = ST_HIT;
    idx_dec       = '0;
    found_dec     = 1'b0;
    if (is_unpin) begin
      status_dec = ST_UNPIN;
      found_dec  = fin.hit;
      idx_dec    = fin.hit ? fin.hit_idx : '0;
      if (fin.hit) begin
        wr_dec.en     = 1'b1;
        wr_dec.idx    = fin.hit_idx;
        wr_dec.pin_we = 1'b1;
        wr_dec.stamp  = stamp1;
        use_clock_nxt = stamp1;
      end
    end else if (!legal) begin
      status_dec = ST_ILLEGAL;
    end else if (empty_r) begin
      // no fill for a zero-size page, but a resident copy can still be pinned
      status_dec = ST_EMPTY;
      found_dec  = fin.hit;
      idx_dec    = fin.hit ? fin.hit_idx : '0;
      if (is_pin && fin.hit) begin
        wr_dec.en      = 1'b1;
        wr_dec.idx     = fin.hit_idx;
        wr_dec.pin_we  = 1'b1;
        wr_dec.pin_val = 1'b1;
        wr_dec.stamp   = stamp1;
        use_clock_nxt  = stamp1;
      end
    end else if (fin.hit) begin
      status_dec     = ST_HIT;
      found_dec      = 1'b1;
      idx_dec        = fin.hit_idx;
      wr_dec.en      = 1'b1;
      wr_dec.idx     = fin.hit_idx;
      wr_dec.pin_we  = is_pin;
      wr_dec.pin_val = 1'b1;
      wr_dec.stamp   = is_pin ? stamp2 : stamp1;
      use_clock_nxt  = is_pin ? stamp2 : stamp1;
    end else if (fin.free || fin.vic) begin
      status_dec     = ST_MISS;
      found_dec      = 1'b1;
      idx_dec        = fin.free ? fin.free_idx : fin.vic_idx;
      wr_dec.en      = 1'b1;
      wr_dec.idx     = idx_dec;
      wr_dec.load    = 1'b1;
      wr_dec.pin_we  = 1'b1;
      wr_dec.pin_val = is_pin;
      wr_dec.stamp   = is_pin ? stamp2 : stamp1;
      use_clock_nxt  = is_pin ? stamp2 : stamp1;
    end else begin
      status_dec = ST_NOSLOT;
    end
  end

  always_comb begin
    wr    = wr_dec;
    wr.en = wr_dec.en && fin.vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
      use_clock_r <= '0;
    end else begin
      launch_r    <= accept;
      out_valid_r <= fin.vld;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (fin.vld) begin
        busy_r <= 1'b0;
      end
      if (fin.vld) begin
        use_clock_r <= use_clock_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      page_r  <= in_page;
      empty_r <= in_page_empty;
    end
    if (fin.vld) begin
      out_status_r <= status_dec;
      out_slot_r   <= slot_field(idx_dec);
      out_found_r  <= found_dec;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_slot_found = out_found_r;

  // config port, word index from the upper address bit
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[ADDR_W-1] == REG_PAGE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r <= '0;
    end else if (cfg_wr) begin
      page_count_r <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[ADDR_W-1] == REG_PAGE_COUNT) ? DATA_W'(page_count_r) : '0;

  `PLCT_ASSERT_NXT(a_busy_after_accept, start && !busy, busy)
  `PLCT_ASSERT_IMP(a_result_needs_item, out_valid, $past(busy))
  `PLCT_ASSERT_NXT(a_single_strobe, out_valid, !out_valid)
  `PLCT_ASSERT_IMP(a_found_status, out_valid && out_slot_found,
                   (out_status != ST_ILLEGAL) && (out_status != ST_NOSLOT))

endmodule

// ===== bench/page_cache_tag_checker.sv =====
// checker for the page cache tag block: tracks page_count, predicts each reply and compares
`timescale 1ns / 100ps
module page_cache_tag_checker import plct_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [FUNC_W-1:0]   in_func,
  input  page_t               in_page,
  input  logic                in_page_empty,
  input  logic                out_valid,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [SLOT_W-1:0]   out_slot,
  input  logic                out_slot_found,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output int                  outstanding,
  output int                  mismatches
);

  localparam logic [ADDR_W-1:0] PAGE_COUNT_ADDR = {REG_PAGE_COUNT, 2'b00};
  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                found;
  } tag_reply_t;

  // predicted copy of the tag store
  logic             slot_used   [SLOTS];
  page_t            slot_tag    [SLOTS];
  stamp_t           slot_age    [SLOTS];
  logic             slot_locked [SLOTS];
  stamp_t           stamp_clock;
  logic [CNT_W-1:0] page_limit;

  tag_reply_t replies_due[$];

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP)
      $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int find_slot(input page_t pg);
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && slot_tag[i] == pg)
        return i;
    return -1;
  endfunction

  // first empty slot, else the unpinned one with the oldest stamp, lowest index on ties
  function automatic int pick_victim();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_used[i])
        return i;
      if (!slot_locked[i] && (best < 0 || slot_age[i] < slot_age[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic stamp_t next_stamp();
    stamp_clock = stamp_clock + 1'b1;
    return stamp_clock;
  endfunction

  task automatic serve_request(input logic [FUNC_W-1:0] fn, input page_t pg,
                               input logic empty, output tag_reply_t r);
    int s;
    logic [STATUS_W-1:0] st;
    if (fn == FUNC_UNPIN) begin
      s = find_slot(pg);
      if (s >= 0) begin
        slot_locked[s] = 1'b0;
        slot_age[s]    = next_stamp();
      end
      st = ST_UNPIN;
    end else begin
      if (pg >= page_limit) begin
        r.status = ST_ILLEGAL;
        r.slot   = '0;
        r.found  = 1'b0;
        return;
      end
      if (empty) begin
        st = ST_EMPTY;
      end else begin
        s = find_slot(pg);
        if (s >= 0) begin
          slot_age[s] = next_stamp();
          st = ST_HIT;
        end else begin
          s = pick_victim();
          if (s < 0) begin
            st = ST_NOSLOT;
          end else begin
            slot_used[s]   = 1'b1;
            slot_tag[s]    = pg;
            slot_age[s]    = next_stamp();
            slot_locked[s] = 1'b0;
            st = ST_MISS;
          end
        end
      end
      // pin applies even to an empty page already held
      if (fn == FUNC_PIN) begin
        s = find_slot(pg);
        if (s >= 0) begin
          slot_locked[s] = 1'b1;
          slot_age[s]    = next_stamp();
        end
      end
    end
    s = find_slot(pg);
    r.status = st;
    r.slot   = (s >= 0) ? SLOT_W'(s) : '0;
    r.found  = (s >= 0);
  endtask

  always @(posedge clk) begin
    tag_reply_t due;
    tag_reply_t fresh;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i]   = 1'b0;
        slot_tag[i]    = '0;
        slot_age[i]    = '0;
        slot_locked[i] = 1'b0;
      end
      stamp_clock = '0;
      page_limit  = '0;
      replies_due.delete();
    end else begin
      // compare before pushing so a same-edge item never matches its own reply
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("result with none due (status %0d slot %0d found %0b)",
                                    out_status, out_slot, out_slot_found));
        end else begin
          due = replies_due.pop_front();
          if (out_status !== due.status)
            report_mismatch($sformatf("status got %0d want %0d", out_status, due.status));
          if (out_slot !== due.slot)
            report_mismatch($sformatf("slot got %0d want %0d", out_slot, due.slot));
          if (out_slot_found !== due.found)
            report_mismatch($sformatf("slot_found got %0b want %0b",
                                      out_slot_found, due.found));
        end
      end
      if (psel && penable && pwrite && pready && paddr == PAGE_COUNT_ADDR)
        page_limit = pwdata[CNT_W-1:0];
      if (start && !busy) begin
        serve_request(in_func, in_page, in_page_empty, fresh);
        replies_due.push_back(fresh);
      end
    end
    outstanding <= replies_due.size();
  end

endmodule

// ===== bench/tb.sv =====
// testbench top: clock, reset, request and register stimulus, watchdog and verdict
`timescale 1ns / 100ps
module tb;
  import plct_pkg::*;

  localparam logic [FUNC_W-1:0]  FUNC_SPARE      = 2'd3;
  localparam logic [ADDR_W-1:0]  PAGE_COUNT_ADDR = {REG_PAGE_COUNT, 2'b00};
  localparam int                 WATCHDOG_LIMIT  = 2000;
  localparam int                 PHASES          = 6;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                start         = 1'b0;
  logic [FUNC_W-1:0]   in_func       = FUNC_GET;
  page_t               in_page       = '0;
  logic                in_page_empty = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ADDR_W-1:0]   paddr         = '0;
  logic [DATA_W-1:0]   pwdata        = '0;
  logic                busy;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_slot_found;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  int                  replies_pending;
  int                  fault_count;
  int                  idle_cycles   = 0;
  logic                quiet_run     = 1'b0;

  always #2 clk = ~clk;

  pinned_lru_page_cache_tags u_dut (
    .clk, .rst_n, .start, .busy, .in_func, .in_page, .in_page_empty,
    .out_valid, .out_status, .out_slot, .out_slot_found,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  page_cache_tag_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_func, .in_page, .in_page_empty,
    .out_valid, .out_status, .out_slot, .out_slot_found,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .outstanding(replies_pending), .mismatches(fault_count)
  );

  // ends the run when nothing moves on any port for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (psel && penable && pwrite && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    return quiet_run ? 0 : $urandom_range(0, 16);
  endfunction

  // start stays high across back-to-back items
  task automatic send_request(input logic [FUNC_W-1:0] fn, input page_t pg,
                              input logic empty);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_func       <= fn;
    in_page       <= pg;
    in_page_empty <= empty;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (replies_pending != 0 || busy);
  endtask

  task automatic write_page_count(input logic [CNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PAGE_COUNT_ADDR;
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [FUNC_W-1:0] draw_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return FUNC_GET;
    if (r < 75) return FUNC_PIN;
    if (r < 95) return FUNC_UNPIN;
    return FUNC_SPARE;
  endfunction

  // mostly a small hot window of pages so slots hit, evict and fill up with pins
  function automatic page_t draw_page(input int hot_base, input int limit);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return page_t'(hot_base + $urandom_range(0, 4));
    if (r < 85) return $urandom_range(0, 1) ? page_t'(limit) : page_t'(limit - 1);
    return page_t'($urandom);
  endfunction

  initial begin
    int limits [PHASES];
    int counts [PHASES];
    int hot_base;
    limits = '{65535, 5, 1, 0, 0, 300};
    counts = '{260, 260, 120, 220, 40, 200};
    limits[3] = $urandom_range(2, 4000);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // page_count is zero out of reset, so every page is illegal
    send_request(FUNC_GET, 16'd0, 1'b0);
    drain();
    write_page_count(16'd8);

    send_request(FUNC_GET,   16'd0,     1'b0);
    send_request(FUNC_GET,   16'd1,     1'b0);
    send_request(FUNC_PIN,   16'd2,     1'b0);
    send_request(FUNC_GET,   16'd0,     1'b0);
    send_request(FUNC_GET,   16'd3,     1'b0);  // evicts the oldest unpinned slot
    send_request(FUNC_UNPIN, 16'd9,     1'b1);  // unpin of a page held nowhere
    send_request(FUNC_PIN,   16'd0,     1'b0);
    send_request(FUNC_PIN,   16'd3,     1'b0);  // every slot now pinned
    send_request(FUNC_GET,   16'd4,     1'b0);
    send_request(FUNC_PIN,   16'd5,     1'b0);
    send_request(FUNC_GET,   16'd2,     1'b1);  // empty page that is resident
    send_request(FUNC_PIN,   16'd1,     1'b1);
    send_request(FUNC_UNPIN, 16'd3,     1'b0);
    send_request(FUNC_SPARE, 16'd6,     1'b0);  // unused code acts as get
    send_request(FUNC_GET,   16'd8,     1'b0);  // first page past the limit
    send_request(FUNC_PIN,   16'hFFFF,  1'b1);
    send_request(FUNC_UNPIN, 16'd0,     1'b0);
    send_request(FUNC_GET,   16'd7,     1'b0);
    send_request(FUNC_UNPIN, 16'hFFFF,  1'b0);
    send_request(FUNC_PIN,   16'd7,     1'b1);  // empty pin still pins a held page
    send_request(FUNC_GET,   16'd7,     1'b0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_page_count(CNT_W'(limits[p]));
      hot_base = (limits[p] > 5) ? $urandom_range(0, limits[p] - 5) : 0;
      for (int n = 0; n < counts[p]; n++) begin
        if (n % 40 == 0)
          quiet_run = ($urandom_range(0, 3) == 0);
        if (n == 100)
          drain();
        send_request(draw_func(), draw_page(hot_base, limits[p]),
                     ($urandom_range(0, 9) == 0));
      end
      drain();
    end

    repeat (SLOTS + 2) @(posedge clk);
    if (fault_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
